// ===== design/spnm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spnm_pkg
// Shared types and SHA-1 constants for the prefix and nonce matcher.
// ----------------------------------------------------------------------------
package spnm_pkg;

	localparam int ROUNDS       = 80;
	localparam int PREFIX_BYTES = 40;
	localparam int SCHED_WORDS  = 16;

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	localparam logic [31:0] H_0 = 32'h67452301;
	localparam logic [31:0] H_1 = 32'hEFCDAB89;
	localparam logic [31:0] H_2 = 32'h98BADCFE;
	localparam logic [31:0] H_3 = 32'h10325476;
	localparam logic [31:0] H_4 = 32'hC3D2E1F0;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Configuration register indexes.
	localparam logic [2:0] REG_PREFIX_0   = 3'd0;
	localparam logic [2:0] REG_PREFIX_1   = 3'd1;
	localparam logic [2:0] REG_PREFIX_2   = 3'd2;
	localparam logic [2:0] REG_PREFIX_3   = 3'd3;
	localparam logic [2:0] REG_PREFIX_4   = 3'd4;
	localparam logic [2:0] REG_TARGET_AB  = 3'd5;
	localparam logic [2:0] REG_TARGET_CD  = 3'd6;
	localparam logic [2:0] REG_TARGET_E   = 3'd7;

	typedef logic [6:0] round_idx_t;

	// Control handed from the sequencer to the round unit.
	typedef struct packed {
		logic       load;
		logic       step;
		round_idx_t round;
	} round_ctl_t;

	// Working variables of the compression.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} hash_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

// ===== design/sha1_prefix_nonce_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_prefix_nonce_matcher
// Builds one SHA-1 block from a configured 40-byte prefix and a nonce,
// hashes it and compares the digest with a configured target.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    nonce_first_bytes,
//                                              nonce_last_bytes, nonce_length
//   out      from block out_valid / out_stall  digest_matches, length_error
//   cfg      to block   cfg_write              cfg_index, cfg_data
//
// A legal item is accepted at the edge that loads the schedule chain and the
// working variables; the single round unit then steps through all 80 rounds,
// and a compare step adds the initial value, compares and fills the output
// register. An item with an illegal length skips the rounds and goes straight
// to the compare step. One item is in work at a time; the next is accepted
// only after the previous result is registered, even if it is stalled. A
// finished item waits in the compare step while the output register holds a
// stalled result.
// Reset clears the configuration registers and the control state.
// ----------------------------------------------------------------------------
module sha1_prefix_nonce_matcher #(
	parameter int MAX_NONCE_BYTES = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] nonce_first_bytes,
	input  logic [55:0] nonce_last_bytes,
	input  logic [3:0]  nonce_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        digest_matches,
	output logic        length_error,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_CMP} state_t;

	state_t                  state_q;
	spnm_pkg::round_idx_t    round_q;
	logic                    err_q;
	logic                    out_valid_q;
	logic                    match_q;
	logic                    lerr_q;

	logic [63:0]             prefix_q [5];
	logic [63:0]             target_ab_q;
	logic [63:0]             target_cd_q;
	logic [31:0]             target_e_q;

	logic                    accept;
	logic                    len_bad;
	logic                    out_free;
	logic [127:0]            nonce_vec;
	logic [7:0]              tail [16];
	logic [31:0]             blk_w [spnm_pkg::SCHED_WORDS];
	logic [31:0]             cell_w [spnm_pkg::SCHED_WORDS];
	logic [31:0]             w_fb;
	logic [5:0]              msg_bytes;
	spnm_pkg::round_ctl_t    rctl;
	spnm_pkg::hash_state_t   hs;
	logic                    digest_eq;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign len_bad  = (nonce_length == 4'd0) || (nonce_length > 4'(MAX_NONCE_BYTES));
	assign out_free = !out_valid_q || !out_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				prefix_q[i] <= '0;
			end
			target_ab_q <= '0;
			target_cd_q <= '0;
			target_e_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				spnm_pkg::REG_PREFIX_0:  prefix_q[0] <= cfg_data;
				spnm_pkg::REG_PREFIX_1:  prefix_q[1] <= cfg_data;
				spnm_pkg::REG_PREFIX_2:  prefix_q[2] <= cfg_data;
				spnm_pkg::REG_PREFIX_3:  prefix_q[3] <= cfg_data;
				spnm_pkg::REG_PREFIX_4:  prefix_q[4] <= cfg_data;
				spnm_pkg::REG_TARGET_AB: target_ab_q <= cfg_data;
				spnm_pkg::REG_TARGET_CD: target_cd_q <= cfg_data;
				spnm_pkg::REG_TARGET_E:  target_e_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Message block: prefix, nonce, pad byte, zeros, bit length.
	assign nonce_vec = {nonce_first_bytes, nonce_last_bytes, 8'h00};
	assign msg_bytes = 6'(spnm_pkg::PREFIX_BYTES) + {2'b00, nonce_length};

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			if (4'(i) < nonce_length) begin
				tail[i] = nonce_vec[127 - 8 * i -: 8];
			end else if (4'(i) == nonce_length) begin
				tail[i] = spnm_pkg::PAD_BYTE;
			end else begin
				tail[i] = 8'h00;
			end
		end
		for (int i = 0; i < 5; i++) begin
			blk_w[2 * i]     = prefix_q[i][63:32];
			blk_w[2 * i + 1] = prefix_q[i][31:0];
		end
		for (int i = 0; i < 4; i++) begin
			blk_w[10 + i] = {tail[4 * i], tail[4 * i + 1], tail[4 * i + 2], tail[4 * i + 3]};
		end
		blk_w[14] = 32'h0;
		blk_w[15] = {23'b0, msg_bytes, 3'b000};
	end

	// Schedule chain: cell j holds W[t+j] during round t.
	assign w_fb = spnm_pkg::rotl(cell_w[13] ^ cell_w[8] ^ cell_w[2] ^ cell_w[0], 1);

	for (genvar j = 0; j < spnm_pkg::SCHED_WORDS; j++) begin : g_cell
		logic [31:0] nxt;
		if (j == spnm_pkg::SCHED_WORDS - 1) begin : g_tail
			assign nxt = w_fb;
		end else begin : g_mid
			assign nxt = cell_w[j + 1];
		end
		spnm_wcell u_cell (
			.clk       (clk),
			.load      (accept),
			.shift     (state_q == ST_RUN),
			.load_word (blk_w[j]),
			.next_word (nxt),
			.word      (cell_w[j])
		);
	end

	assign rctl.load  = accept;
	assign rctl.step  = (state_q == ST_RUN);
	assign rctl.round = round_q;

	spnm_round u_round (
		.clk (clk),
		.ctl (rctl),
		.w   (cell_w[0]),
		.hs  (hs)
	);

	assign digest_eq = ((hs.a + spnm_pkg::H_0) == target_ab_q[63:32]) &&
	                   ((hs.b + spnm_pkg::H_1) == target_ab_q[31:0]) &&
	                   ((hs.c + spnm_pkg::H_2) == target_cd_q[63:32]) &&
	                   ((hs.d + spnm_pkg::H_3) == target_cd_q[31:0]) &&
	                   ((hs.e + spnm_pkg::H_4) == target_e_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			match_q     <= 1'b0;
			lerr_q      <= 1'b0;
		end else begin
			// A new result takes the output register; otherwise a taken one leaves it.
			if (state_q == ST_CMP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						round_q <= '0;
						err_q   <= len_bad;
						state_q <= len_bad ? ST_CMP : ST_RUN;
					end
				end
				ST_RUN: begin
					round_q <= round_q + 7'd1;
					if (round_q == 7'(spnm_pkg::ROUNDS - 1)) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (out_free) begin
						match_q <= !err_q && digest_eq;
						lerr_q  <= err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign digest_matches = match_q;
	assign length_error   = lerr_q;

endmodule

// ===== design/spnm_wcell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spnm_wcell
// One cell of the message schedule chain: holds one 32-bit schedule word
// and takes its neighbor's word on every shift.
// ----------------------------------------------------------------------------
module spnm_wcell (
	input  logic        clk,
	input  logic        load,
	input  logic        shift,
	input  logic [31:0] load_word,
	input  logic [31:0] next_word,
	output logic [31:0] word
);

	logic [31:0] word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end else if (shift) begin
			word_q <= next_word;
		end
	end

	assign word = word_q;

endmodule

// ===== design/spnm_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spnm_round
// SHA-1 round unit: the five working variables and one round of logic,
// reused for all eighty rounds.
// ----------------------------------------------------------------------------
module spnm_round (
	input  logic                    clk,
	input  spnm_pkg::round_ctl_t    ctl,
	input  logic [31:0]             w,
	output spnm_pkg::hash_state_t   hs
);

	spnm_pkg::hash_state_t hs_q;
	logic [31:0]           f;
	logic [31:0]           k;
	logic [31:0]           t;

	always_comb begin
		if (ctl.round < 7'd20) begin
			f = (hs_q.b & hs_q.c) | (~hs_q.b & hs_q.d);
			k = spnm_pkg::K_0;
		end else if (ctl.round < 7'd40) begin
			f = hs_q.b ^ hs_q.c ^ hs_q.d;
			k = spnm_pkg::K_1;
		end else if (ctl.round < 7'd60) begin
			f = (hs_q.b & hs_q.c) | (hs_q.b & hs_q.d) | (hs_q.c & hs_q.d);
			k = spnm_pkg::K_2;
		end else begin
			f = hs_q.b ^ hs_q.c ^ hs_q.d;
			k = spnm_pkg::K_3;
		end
		t = spnm_pkg::rotl(hs_q.a, 5) + f + hs_q.e + w + k;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hs_q.a <= spnm_pkg::H_0;
			hs_q.b <= spnm_pkg::H_1;
			hs_q.c <= spnm_pkg::H_2;
			hs_q.d <= spnm_pkg::H_3;
			hs_q.e <= spnm_pkg::H_4;
		end else if (ctl.step) begin
			hs_q.e <= hs_q.d;
			hs_q.d <= hs_q.c;
			hs_q.c <= spnm_pkg::rotl(hs_q.b, 30);
			hs_q.b <= hs_q.a;
			hs_q.a <= t;
		end
	end

	assign hs = hs_q;

endmodule

// ===== design/spnm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spnm_checker
// Port-level checks for the prefix and nonce matcher, bound to the top level.
// ----------------------------------------------------------------------------
module spnm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic digest_matches,
	input logic length_error
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(digest_matches) && $stable(length_error))
		else $error("result changed while stalled");

	// An illegal length never reports a match.
	a_err_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_error |-> !digest_matches)
		else $error("match reported with length error");

	// The block works on one item at a time, so it is busy right after an accept.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while one is in work");

	// No result is offered before the first item has been taken.
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without an item in work");

endmodule

bind sha1_prefix_nonce_matcher spnm_checker u_spnm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.digest_matches (digest_matches),
	.length_error   (length_error)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SHA-1 prefix and nonce matcher. A directed
// table covers illegal lengths, the shortest and longest nonces, ignored
// trailing bytes and targets aimed at a known nonce. Random phases follow,
// each writing a new prefix and target, under several idling patterns and one
// long output hold-off. Every result is checked against its typed flags or
// against a SHA-1 predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 155;
	localparam int HOLD_PHASE      = 4;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 100;
	localparam int DIR_ROWS        = 20;

	typedef struct packed {
		logic hit;
		logic len_err;
	} flags_t;

	typedef enum logic {
		ROW_SEND,
		ROW_AIM
	} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic [119:0] nonce;
		logic [3:0]   len;
		logic         typed;
		logic         exp_match;
		logic         exp_err;
	} dir_row_t;

	// Rows with typed flags follow directly from the length and target rules;
	// the rest go to the predictor. An aim row first points the target at its
	// own nonce.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_SEND, 120'h0, 4'd0, 1'b1, 1'b0, 1'b1},
		'{ROW_SEND, {120{1'b1}}, 4'd0, 1'b1, 1'b0, 1'b1},
		'{ROW_SEND, 120'h0, 4'd1, 1'b1, 1'b0, 1'b0},
		'{ROW_SEND, {120{1'b1}}, 4'd15, 1'b1, 1'b0, 1'b0},
		'{ROW_SEND, 120'h0, 4'd15, 1'b1, 1'b0, 1'b0},
		'{ROW_SEND, {15{8'h55}}, 4'd8, 1'b0, 1'b0, 1'b0},
		'{ROW_SEND, {15{8'hAA}}, 4'd7, 1'b0, 1'b0, 1'b0},
		'{ROW_SEND, "0123456789abcde", 4'd9, 1'b0, 1'b0, 1'b0},
		'{ROW_AIM, "0123456789abcde", 4'd15, 1'b1, 1'b1, 1'b0},
		'{ROW_SEND, "0123456789abcde", 4'd15, 1'b1, 1'b1, 1'b0},
		'{ROW_SEND, "0123456789abcde", 4'd14, 1'b0, 1'b0, 1'b0},
		'{ROW_AIM, {8'h7A, 112'h0}, 4'd1, 1'b1, 1'b1, 1'b0},
		'{ROW_SEND, {8'h7A, {112{1'b1}}}, 4'd1, 1'b1, 1'b1, 1'b0},
		'{ROW_SEND, {8'h7A, 112'h0}, 4'd0, 1'b1, 1'b0, 1'b1},
		'{ROW_SEND, {8'h7A, 112'h0}, 4'd2, 1'b0, 1'b0, 1'b0},
		'{ROW_AIM, {"nonce-08", 56'h0}, 4'd8, 1'b1, 1'b1, 1'b0},
		'{ROW_SEND, {"nonce-08", 56'hC35A0FF09669E1}, 4'd8, 1'b1, 1'b1, 1'b0},
		'{ROW_SEND, {"nonce-08", 56'hC35A0FF09669E1}, 4'd9, 1'b0, 1'b0, 1'b0},
		'{ROW_AIM, {120{1'b1}}, 4'd15, 1'b1, 1'b1, 1'b0},
		'{ROW_SEND, {120{1'b1}}, 4'd14, 1'b0, 1'b0, 1'b0}
	};

	int send_pcts [4] = '{0, 83, 0, 34};
	int recv_pcts [4] = '{0, 0, 83, 34};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] nonce_first_bytes;
	logic [55:0] nonce_last_bytes;
	logic [3:0]  nonce_length;
	logic        out_valid;
	logic        out_stall;
	logic        digest_matches;
	logic        length_error;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	// Typed flags travel with the item so the acceptance monitor can use them.
	logic   drv_typed;
	flags_t drv_flags;

	logic [63:0] reg_copy [8];
	logic [63:0] reg_staged [8];
	flags_t      expected_flags [$];
	flags_t      oldest;
	int          mismatches;
	int          phase_idx;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_done;

	sha1_prefix_nonce_matcher u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.nonce_first_bytes (nonce_first_bytes),
		.nonce_last_bytes  (nonce_last_bytes),
		.nonce_length      (nonce_length),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.digest_matches    (digest_matches),
		.length_error      (length_error),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Digest of the block built from the current prefix copy and the nonce.
	function automatic logic [159:0] sha1_digest(input logic [119:0] nonce,
			input logic [3:0] len);
		logic [7:0]   blk [64];
		logic [31:0]  w [80];
		logic [319:0] pre;
		logic [31:0]  a, b, c, d, e, f, k, t, x;
		int           msg_bits;
		pre = {reg_copy[spnm_pkg::REG_PREFIX_0], reg_copy[spnm_pkg::REG_PREFIX_1],
			reg_copy[spnm_pkg::REG_PREFIX_2], reg_copy[spnm_pkg::REG_PREFIX_3],
			reg_copy[spnm_pkg::REG_PREFIX_4]};
		for (int i = 0; i < 64; i++) blk[i] = 8'h00;
		for (int i = 0; i < spnm_pkg::PREFIX_BYTES; i++) blk[i] = pre[319 - 8 * i -: 8];
		for (int i = 0; i < len; i++)
			blk[spnm_pkg::PREFIX_BYTES + i] = nonce[119 - 8 * i -: 8];
		blk[spnm_pkg::PREFIX_BYTES + len] = spnm_pkg::PAD_BYTE;
		msg_bits = (spnm_pkg::PREFIX_BYTES + len) * 8;
		blk[62] = msg_bits[15:8];
		blk[63] = msg_bits[7:0];
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
		for (int i = 16; i < spnm_pkg::ROUNDS; i++) begin
			x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
			w[i] = {x[30:0], x[31]};
		end
		a = spnm_pkg::H_0;
		b = spnm_pkg::H_1;
		c = spnm_pkg::H_2;
		d = spnm_pkg::H_3;
		e = spnm_pkg::H_4;
		for (int i = 0; i < spnm_pkg::ROUNDS; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = spnm_pkg::K_0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = spnm_pkg::K_1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = spnm_pkg::K_2;
			end else begin
				f = b ^ c ^ d;
				k = spnm_pkg::K_3;
			end
			t = {a[26:0], a[31:27]} + f + e + w[i] + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		return {a + spnm_pkg::H_0, b + spnm_pkg::H_1, c + spnm_pkg::H_2,
			d + spnm_pkg::H_3, e + spnm_pkg::H_4};
	endfunction

	function automatic flags_t predict_flags(input logic [119:0] nonce,
			input logic [3:0] len);
		flags_t r;
		r.len_err = (len == 4'd0);
		r.hit = !r.len_err && (sha1_digest(nonce, len) ==
			{reg_copy[spnm_pkg::REG_TARGET_AB], reg_copy[spnm_pkg::REG_TARGET_CD],
			reg_copy[spnm_pkg::REG_TARGET_E][31:0]});
		return r;
	endfunction

	function automatic logic [119:0] rand_nonce();
		logic [127:0] r;
		r = {$urandom, $urandom, $urandom, $urandom};
		return r[119:0];
	endfunction

	task automatic write_regs(input int lo, input int hi);
		for (int i = lo; i <= hi; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= reg_staged[i];
			reg_copy[i] = (i == spnm_pkg::REG_TARGET_E) ? {32'h0, reg_staged[i][31:0]}
				: reg_staged[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	// Points the target at the digest of the given nonce; the upper half of the
	// word E write carries junk that the block must drop.
	task automatic aim_target(input logic [119:0] nonce, input logic [3:0] len);
		logic [159:0] dg;
		dg = sha1_digest(nonce, len);
		reg_staged[spnm_pkg::REG_TARGET_AB] = dg[159:96];
		reg_staged[spnm_pkg::REG_TARGET_CD] = dg[95:32];
		reg_staged[spnm_pkg::REG_TARGET_E]  = {$urandom, dg[31:0]};
		write_regs(spnm_pkg::REG_TARGET_AB, spnm_pkg::REG_TARGET_E);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_flags.size() != 0) @(posedge clk);
	endtask

	task automatic send_nonce(input logic [119:0] nonce, input logic [3:0] len,
			input logic typed, input flags_t flags);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		nonce_first_bytes <= nonce[119:56];
		nonce_last_bytes  <= nonce[55:0];
		nonce_length      <= len;
		drv_typed         <= typed;
		drv_flags         <= flags;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			expected_flags.push_back(drv_typed ? drv_flags
				: predict_flags({nonce_first_bytes, nonce_last_bytes}, nonce_length));
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_flags.size() == 0) begin
				$display("%0t: result with none expected: matches %b error %b", $time,
					digest_matches, length_error);
				mismatches++;
			end else begin
				oldest = expected_flags.pop_front();
				if (digest_matches !== oldest.hit) begin
					$display("%0t: digest_matches expected %b actual %b", $time,
						oldest.hit, digest_matches);
					mismatches++;
				end
				if (length_error !== oldest.len_err) begin
					$display("%0t: length_error expected %b actual %b", $time,
						oldest.len_err, length_error);
					mismatches++;
				end
			end
		end
	end

	// Output side: random stalls, plus one long hold-off that fills the block.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (phase_idx == HOLD_PHASE && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		logic [119:0] seed_nonce;
		logic [119:0] nonce;
		logic [3:0]   seed_len;
		logic [3:0]   len;
		int           pick;

		arst_n            = 1'b0;
		in_valid          = 1'b0;
		nonce_first_bytes = '0;
		nonce_last_bytes  = '0;
		nonce_length      = '0;
		cfg_write         = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		drv_typed         = 1'b0;
		drv_flags         = '0;
		mismatches        = 0;
		phase_idx         = -1;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		hold_done         = 1'b0;
		for (int i = 0; i < 8; i++) reg_copy[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_AIM) begin
				wait_idle();
				aim_target(dir_rows[r].nonce, dir_rows[r].len);
			end
			send_nonce(dir_rows[r].nonce, dir_rows[r].len, dir_rows[r].typed,
				'{hit: dir_rows[r].exp_match, len_err: dir_rows[r].exp_err});
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			for (int i = spnm_pkg::REG_PREFIX_0; i <= spnm_pkg::REG_PREFIX_4; i++) begin
				if (p == 0)
					reg_staged[i] = '1;
				else if (p % 3 == 1)
					reg_staged[i] = '0;
				else
					reg_staged[i] = {$urandom, $urandom};
			end
			write_regs(spnm_pkg::REG_PREFIX_0, spnm_pkg::REG_PREFIX_4);
			seed_nonce = rand_nonce();
			seed_len   = 4'($urandom_range(1, 15));
			if (p == 0) begin
				reg_staged[spnm_pkg::REG_TARGET_AB] = '1;
				reg_staged[spnm_pkg::REG_TARGET_CD] = '1;
				reg_staged[spnm_pkg::REG_TARGET_E]  = '1;
				write_regs(spnm_pkg::REG_TARGET_AB, spnm_pkg::REG_TARGET_E);
			end else begin
				aim_target(seed_nonce, seed_len);
			end
			send_idle_pct  = send_pcts[p % 4];
			recv_stall_pct = recv_pcts[p % 4];
			phase_idx      = p;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick  = $urandom_range(99);
				nonce = rand_nonce();
				if (pick < 30) begin
					// The aimed nonce with random bytes past its length.
					len = seed_len;
					for (int b = 0; b < seed_len; b++)
						nonce[119 - 8 * b -: 8] = seed_nonce[119 - 8 * b -: 8];
				end else if (pick < 36) begin
					len = 4'd0;
				end else begin
					len = 4'($urandom_range(1, 15));
				end
				send_nonce(nonce, len, 1'b0, '0);
			end
		end

		wait_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_flags.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
